[src/assert_macros.svh]
// assertion macros used by multichannel_pid_speed_controller
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MPID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define MPID_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/mpid_pkg.sv]
// types and fixed constants of the multichannel pid speed controller
// no dependencies; used by multichannel_pid_speed_controller
package mpid_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [1:0] REG_DERIV_GAIN = 2'd2;

    // loop constants
    localparam int DERIV_MIN       = 50;
    localparam int DERIV_MAX       = 2400;
    localparam int DERIV_OUT_SCALE = 50;
    localparam int INTEG_UNIT      = 5000;
    localparam int INTEG_LIMIT     = 400000;
    localparam int DRIVE_LIMIT     = 127;
    // smallest sum magnitude whose quotient exceeds the drive limit
    localparam int DRIVE_SAT       = (DRIVE_LIMIT + 1) * INTEG_UNIT;

    // reciprocal of 100: exact floor for 24-bit magnitudes
    localparam logic [24:0] RECIP_100  = 25'd21474837;
    localparam int          RECIP_100_SH = 31;
    // reciprocal of 5000: exact floor for 20-bit magnitudes
    localparam logic [20:0] RECIP_5000 = 21'd1717987;
    localparam int          RECIP_5000_SH = 33;

    // tag that travels with each request down the pipeline
    typedef struct packed {
        logic       ok;
        logic [1:0] ch;
    } tag_t;

endpackage

[src/multichannel_pid_speed_controller.sv]
// multichannel pid speed controller, top level
// depends on mpid_pkg and assert_macros.svh
//
// Takes one request per clock cycle and returns one drive value per request,
// in order. Each request passes stages one to seven, then the output register.
// Throughput is one request per cycle: the per-channel last error and integral
// live in two small state memories that are read in stage one and written
// back in stage two, and a one-entry bypass serves requests for the same
// channel that follow each other directly. Any stage holding a bubble can
// take new work while a finished drive value waits, so the input stalls only
// once all seven stages and the output register are full. Loop state reads as
// zero after reset through one flag per channel, so there is no clearing pass.
// The user is to write gains only while idle; the block does not enforce it.
`include "assert_macros.svh"

module multichannel_pid_speed_controller #(
    parameter int CHANNELS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_en,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        channel,
    input  logic signed [15:0] setpoint,
    input  logic signed [15:0] feedback,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        drive_channel,
    output logic signed [7:0] drive
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // gain registers
    logic [7:0] prop_gain_reg;
    logic [7:0] integ_gain_reg;
    logic [7:0] deriv_gain_reg;

    // pipeline control
    logic [7:1]          vld_reg;
    logic [7:1]          free;
    logic                free_out;
    mpid_pkg::tag_t      tag_reg [7:1];
    mpid_pkg::tag_t      tag0;

    // state memories, bypass and per-channel valid flags
    logic signed [16:0]  err_mem [CHANNELS];
    logic signed [19:0]  acc_mem [CHANNELS];
    logic signed [16:0]  rd_err_reg;
    logic signed [19:0]  rd_acc_reg;
    logic [CHANNELS-1:0] ent_vld_reg;
    logic                fwd_vld_reg;
    logic [AW-1:0]       fwd_addr_reg;
    logic signed [16:0]  fwd_err_reg;
    logic signed [19:0]  fwd_acc_reg;

    // stage payloads
    logic signed [16:0]  err0;
    logic signed [16:0]  err1_reg;
    logic signed [24:0]  pprod1;
    logic signed [24:0]  iprod1;
    logic signed [16:0]  err2_reg;
    logic signed [24:0]  pprod2_reg;
    logic signed [24:0]  iprod2_reg;
    logic [AW+1:0]       ch_ext1;
    logic [AW+1:0]       ch_ext2;
    logic [AW-1:0]       addr1;
    logic [AW-1:0]       addr2;
    logic                fwd_hit;
    logic signed [16:0]  last_err;
    logic signed [19:0]  acc_old;
    logic signed [17:0]  diff2;
    logic signed [21:0]  d10;
    logic                d_zero;
    logic signed [12:0]  dval2;
    logic signed [25:0]  asum2;
    logic signed [19:0]  acc_new;
    logic                wr_en;
    logic signed [24:0]  pprod3_reg;
    logic signed [12:0]  dval3_reg;
    logic signed [19:0]  acc3_reg;
    logic                pneg3;
    logic [23:0]         pmag3;
    logic [48:0]         pq_full;
    logic signed [20:0]  kdd3;
    logic [17:0]         pq4_reg;
    logic                pneg4_reg;
    logic signed [20:0]  kdd4_reg;
    logic signed [19:0]  acc4_reg;
    logic [6:0]          pclamp4;
    logic signed [7:0]   p4;
    logic signed [20:0]  p5000_4;
    logic signed [25:0]  kdd50_4;
    logic signed [20:0]  p5000_5_reg;
    logic signed [25:0]  kdd50_5_reg;
    logic signed [19:0]  acc5_reg;
    logic signed [25:0]  sum5;
    logic signed [25:0]  sum6_reg;
    logic                sneg6;
    logic [24:0]         smag6;
    logic                big6;
    logic [40:0]         uq_full;
    logic [6:0]          uq7_reg;
    logic                big7_reg;
    logic                sneg7_reg;
    logic [6:0]          umag7;
    logic signed [7:0]   drive_next;

    // output register
    logic                out_valid_reg;
    logic [1:0]          drive_channel_reg;
    logic signed [7:0]   drive_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                mpid_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                mpid_pkg::REG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                mpid_pkg::REG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its item moves on
    always_comb
    begin
        free_out = !out_valid_reg || out_ready;
        free[7]  = !vld_reg[7] || free_out;
        free[6]  = !vld_reg[6] || free[7];
        free[5]  = !vld_reg[5] || free[6];
        free[4]  = !vld_reg[4] || free[5];
        free[3]  = !vld_reg[3] || free[4];
        free[2]  = !vld_reg[2] || free[3];
        free[1]  = !vld_reg[1] || free[2];
    end

    assign in_ready = free[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (free[1]) vld_reg[1] <= in_valid;
            if (free[2]) vld_reg[2] <= vld_reg[1];
            if (free[3]) vld_reg[3] <= vld_reg[2];
            if (free[4]) vld_reg[4] <= vld_reg[3];
            if (free[5]) vld_reg[5] <= vld_reg[4];
            if (free[6]) vld_reg[6] <= vld_reg[5];
            if (free[7]) vld_reg[7] <= vld_reg[6];
        end
    end

    // stage 0: channel check and error at full width
    assign tag0.ch = channel;
    assign tag0.ok = 32'(channel) < 32'(CHANNELS);
    assign err0    = 17'(setpoint) - 17'(feedback);

    // tag shift line
    always_ff @(posedge clk)
    begin
        if (free[1]) tag_reg[1] <= tag0;
        if (free[2]) tag_reg[2] <= tag_reg[1];
        if (free[3]) tag_reg[3] <= tag_reg[2];
        if (free[4]) tag_reg[4] <= tag_reg[3];
        if (free[5]) tag_reg[5] <= tag_reg[4];
        if (free[6]) tag_reg[6] <= tag_reg[5];
        if (free[7]) tag_reg[7] <= tag_reg[6];
    end

    // stage 1: gain products, state read issued
    assign pprod1  = 25'(err1_reg) * 25'($signed({1'b0, prop_gain_reg}));
    assign iprod1  = 25'(err1_reg) * 25'($signed({1'b0, integ_gain_reg}));
    assign ch_ext1 = {{AW{1'b0}}, tag_reg[1].ch};
    assign addr1   = ch_ext1[AW-1:0];

    // stage 2: read-modify-write of channel state
    assign ch_ext2 = {{AW{1'b0}}, tag_reg[2].ch};
    assign addr2   = ch_ext2[AW-1:0];
    assign fwd_hit = fwd_vld_reg && (fwd_addr_reg == addr2);

    always_comb
    begin
        if (fwd_hit)
        begin
            last_err = fwd_err_reg;
            acc_old  = fwd_acc_reg;
        end
        else if (ent_vld_reg[addr2])
        begin
            last_err = rd_err_reg;
            acc_old  = rd_acc_reg;
        end
        else
        begin
            last_err = '0;
            acc_old  = '0;
        end
    end

    // derivative with dead band and spike reject
    assign diff2  = 18'(err2_reg) - 18'(last_err);
    assign d10    = (22'(diff2) <<< 3) + (22'(diff2) <<< 1);
    assign d_zero = ((d10 > 22'(-mpid_pkg::DERIV_MIN)) && (d10 < 22'(mpid_pkg::DERIV_MIN)))
                    || (d10 > 22'(mpid_pkg::DERIV_MAX))
                    || (d10 < 22'(-mpid_pkg::DERIV_MAX));
    assign dval2  = d_zero ? '0 : 13'(d10);

    // integral update with saturation
    assign asum2 = 26'(acc_old) + 26'(iprod2_reg);

    always_comb
    begin
        if (asum2 > 26'(mpid_pkg::INTEG_LIMIT))
            acc_new = 20'(mpid_pkg::INTEG_LIMIT);
        else if (asum2 < 26'(-mpid_pkg::INTEG_LIMIT))
            acc_new = 20'(-mpid_pkg::INTEG_LIMIT);
        else
            acc_new = 20'(asum2);
    end

    assign wr_en = vld_reg[2] && tag_reg[2].ok && free[3];

    // state memories
    always_ff @(posedge clk)
    begin
        if (free[2])
        begin
            rd_err_reg <= err_mem[addr1];
            rd_acc_reg <= acc_mem[addr1];
        end
        if (wr_en)
        begin
            err_mem[addr2] <= err2_reg;
            acc_mem[addr2] <= acc_new;
        end
    end

    // channel valid flags and write bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg  <= '0;
            fwd_vld_reg  <= 1'b0;
            fwd_addr_reg <= '0;
            fwd_err_reg  <= '0;
            fwd_acc_reg  <= '0;
        end
        else if (wr_en)
        begin
            ent_vld_reg[addr2] <= 1'b1;
            fwd_vld_reg        <= 1'b1;
            fwd_addr_reg       <= addr2;
            fwd_err_reg        <= err2_reg;
            fwd_acc_reg        <= acc_new;
        end
    end

    // stage 3: proportional divide by 100, derivative gain
    assign pneg3   = pprod3_reg[24];
    assign pmag3   = pneg3 ? 24'(-pprod3_reg) : 24'(pprod3_reg);
    assign pq_full = 49'(pmag3) * 49'(mpid_pkg::RECIP_100);
    assign kdd3    = 21'(dval3_reg) * 21'($signed({1'b0, deriv_gain_reg}));

    // stage 4: proportional clamp, scale to integral units
    assign pclamp4 = (pq4_reg > 18'(mpid_pkg::DRIVE_LIMIT)) ?
                     7'(mpid_pkg::DRIVE_LIMIT) : 7'(pq4_reg);
    assign p4      = pneg4_reg ? -$signed({1'b0, pclamp4}) : $signed({1'b0, pclamp4});
    assign p5000_4 = 21'(p4) * 21'(mpid_pkg::INTEG_UNIT);
    assign kdd50_4 = 26'(kdd4_reg) * 26'(mpid_pkg::DERIV_OUT_SCALE);

    // stage 5: sum of the three terms
    assign sum5 = 26'(p5000_5_reg) + 26'(acc5_reg) + kdd50_5_reg;

    // stage 6: divide by 5000 through the reciprocal
    assign sneg6   = sum6_reg[25];
    assign smag6   = sneg6 ? 25'(-sum6_reg) : 25'(sum6_reg);
    assign big6    = smag6 >= 25'(mpid_pkg::DRIVE_SAT);
    assign uq_full = 41'(smag6[19:0]) * 41'(mpid_pkg::RECIP_5000);

    // stage 7: clamp and sign, zero for an absent channel
    assign umag7      = big7_reg ? 7'(mpid_pkg::DRIVE_LIMIT) : uq7_reg;
    assign drive_next = !tag_reg[7].ok ? '0 :
                        sneg7_reg ? -$signed({1'b0, umag7}) : $signed({1'b0, umag7});

    // stage payload registers
    always_ff @(posedge clk)
    begin
        if (free[1])
        begin
            err1_reg <= err0;
        end
        if (free[2])
        begin
            err2_reg   <= err1_reg;
            pprod2_reg <= pprod1;
            iprod2_reg <= iprod1;
        end
        if (free[3])
        begin
            pprod3_reg <= pprod2_reg;
            dval3_reg  <= dval2;
            acc3_reg   <= acc_new;
        end
        if (free[4])
        begin
            pq4_reg   <= pq_full[mpid_pkg::RECIP_100_SH +: 18];
            pneg4_reg <= pneg3;
            kdd4_reg  <= kdd3;
            acc4_reg  <= acc3_reg;
        end
        if (free[5])
        begin
            p5000_5_reg <= p5000_4;
            kdd50_5_reg <= kdd50_4;
            acc5_reg    <= acc4_reg;
        end
        if (free[6])
        begin
            sum6_reg <= sum5;
        end
        if (free[7])
        begin
            uq7_reg   <= uq_full[mpid_pkg::RECIP_5000_SH +: 7];
            big7_reg  <= big6;
            sneg7_reg <= sneg6;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (free_out)
        begin
            out_valid_reg <= vld_reg[7];
        end
    end

    always_ff @(posedge clk)
    begin
        if (free_out)
        begin
            drive_channel_reg <= tag_reg[7].ch;
            drive_reg         <= drive_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_channel = drive_channel_reg;
    assign drive         = drive_reg;

    // checks
    `MPID_NEVER(a_drive_range, out_valid && (drive == 8'sh80), "drive below negative limit")
    `MPID_ASSERT(a_absent_chan, out_valid && (32'(drive_channel) >= 32'(CHANNELS)) |-> (drive == 8'sd0), "absent channel drives nonzero")
    `MPID_ASSERT(a_full_stall, (&vld_reg) && out_valid && !out_ready |-> !in_ready, "request taken with pipeline full")
    `MPID_ASSERT(a_acc_bound, wr_en |-> (acc_new <= 20'sd400000) && (acc_new >= -20'sd400000), "integral written beyond limit")

endmodule
